// File: rtl/ils_pkg.sv
// Package for the indexed list store: sizes, operation and status codes,
// and the command record passed from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ils_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STAT_W   = 2;
    localparam int LEN_W    = 7;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Read select tree: groups of GRP cells are OR-reduced in the first stage.
    localparam int GRP  = 8;
    localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

    // Command queue between front end and back end.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_READ     = 3'd0,
        OP_INS_HEAD = 3'd1,
        OP_INS_TAIL = 3'd2,
        OP_INS_AT   = 3'd3,
        OP_DELETE   = 3'd4
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_READ   = 2'd1,
        ACT_INSERT = 2'd2,
        ACT_DELETE = 2'd3
    } t_act;

    typedef struct packed {
        t_act                     act;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] value;
        t_status                  status;
        logic [LEN_W-1:0]         length;
    } t_cmd;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_READ = 1'b1
    } t_back_state;

    typedef struct packed {
        logic reading;
        logic pop;
    } t_back_stat;

endpackage

`default_nettype wire

// File: rtl/ils_front.sv
// Front end of the indexed list store: accepts request beats, tracks the
// list length and turns each request into a resolved command.
// Depends on ils_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ils_front (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire  [ils_pkg::OP_W-1:0]         i_op,
    input  wire  [ils_pkg::POS_W-1:0]        i_position,
    input  wire  signed [ils_pkg::DATA_W-1:0] i_value,
    output logic                             o_push,
    output ils_pkg::t_cmd                    o_cmd,
    input  wire                              i_full
);

    logic [ils_pkg::CNT_W-1:0] r_count;
    logic [ils_pkg::CNT_W-1:0] n_count;

    always_comb begin
        logic [ils_pkg::CMP_W-1:0] pos_c;
        logic [ils_pkg::CMP_W-1:0] cnt_c;
        logic                      is_full;
        logic                      do_ins;
        logic [ils_pkg::IDX_W-1:0] ins_idx;

        pos_c   = ils_pkg::CMP_W'(i_position);
        cnt_c   = ils_pkg::CMP_W'(r_count);
        is_full = (r_count == ils_pkg::CNT_W'(ils_pkg::CAPACITY));
        do_ins  = 1'b0;
        ins_idx = '0;

        n_count      = r_count;
        o_cmd.act    = ils_pkg::ACT_NONE;
        o_cmd.idx    = '0;
        o_cmd.value  = '0;
        o_cmd.status = ils_pkg::ST_DONE;

        case (ils_pkg::t_op'(i_op))
            ils_pkg::OP_READ: begin
                if (pos_c < cnt_c) begin
                    o_cmd.act = ils_pkg::ACT_READ;
                    o_cmd.idx = ils_pkg::IDX_W'(i_position);
                end else begin
                    o_cmd.value  = '1;
                    o_cmd.status = ils_pkg::ST_RANGE;
                end
            end
            ils_pkg::OP_INS_HEAD: begin
                do_ins  = 1'b1;
                ins_idx = '0;
            end
            ils_pkg::OP_INS_TAIL: begin
                do_ins  = 1'b1;
                ins_idx = ils_pkg::IDX_W'(r_count);
            end
            ils_pkg::OP_INS_AT: begin
                // The index check wins over the full check.
                if (pos_c > cnt_c) begin
                    o_cmd.status = ils_pkg::ST_RANGE;
                end else begin
                    do_ins  = 1'b1;
                    ins_idx = ils_pkg::IDX_W'(i_position);
                end
            end
            ils_pkg::OP_DELETE: begin
                if (pos_c >= cnt_c) begin
                    o_cmd.status = ils_pkg::ST_RANGE;
                end else begin
                    o_cmd.act = ils_pkg::ACT_DELETE;
                    o_cmd.idx = ils_pkg::IDX_W'(i_position);
                    n_count   = r_count - 1'b1;
                end
            end
            default: begin
                o_cmd.status = ils_pkg::ST_RANGE;
            end
        endcase

        if (do_ins) begin
            if (is_full) begin
                o_cmd.status = ils_pkg::ST_FULL;
            end else begin
                o_cmd.act   = ils_pkg::ACT_INSERT;
                o_cmd.idx   = ins_idx;
                o_cmd.value = i_value;
                n_count     = r_count + 1'b1;
            end
        end

        o_cmd.length = ils_pkg::LEN_W'(n_count);
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_push) begin
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ils_queue.sv
// Short command queue between the front end and the back end of the
// indexed list store. Depends on ils_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ils_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  ils_pkg::t_cmd  i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output ils_pkg::t_cmd  o_cmd,
    input  wire            i_pop
);

    ils_pkg::t_cmd              r_mem [ils_pkg::QDEPTH];
    logic [ils_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [ils_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [ils_pkg::QCNT_W-1:0] r_fill;

    assign o_full  = (r_fill == ils_pkg::QCNT_W'(ils_pkg::QDEPTH));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/ils_back.sv
// Back end of the indexed list store: the row of shifting entry cells,
// the two-stage read select tree and the result register.
// Depends on ils_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ils_back (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_q_valid,
    input  ils_pkg::t_cmd                     i_cmd,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire                               i_ready,
    output logic signed [ils_pkg::DATA_W-1:0] o_read_value,
    output logic [ils_pkg::STAT_W-1:0]        o_status,
    output logic [ils_pkg::LEN_W-1:0]         o_length,
    output ils_pkg::t_back_stat               o_stat
);

    logic signed [ils_pkg::DATA_W-1:0] r_cells [ils_pkg::CAPACITY];
    logic signed [ils_pkg::DATA_W-1:0] n_cells [ils_pkg::CAPACITY];
    logic [ils_pkg::DATA_W-1:0]        r_grp   [ils_pkg::NGRP];
    logic [ils_pkg::DATA_W-1:0]        n_grp   [ils_pkg::NGRP];
    logic [ils_pkg::DATA_W-1:0]        sel_word;

    ils_pkg::t_back_state r_state;
    ils_pkg::t_back_state n_state;
    ils_pkg::t_cmd        r_cmd;

    logic                              r_out_valid;
    logic                              n_out_valid;
    logic signed [ils_pkg::DATA_W-1:0] r_rd_value;
    logic [ils_pkg::STAT_W-1:0]        r_status;
    logic [ils_pkg::LEN_W-1:0]         r_length;
    logic                              load_out;
    logic                              load_read;

    // Next contents of every cell for the command at the queue head.
    always_comb begin
        for (int k = 0; k < ils_pkg::CAPACITY; k++) begin
            n_cells[k] = r_cells[k];
        end
        if (i_cmd.act == ils_pkg::ACT_INSERT) begin
            for (int k = 1; k < ils_pkg::CAPACITY; k++) begin
                if (ils_pkg::IDX_W'(k) > i_cmd.idx) begin
                    n_cells[k] = r_cells[k-1];
                end
            end
            for (int k = 0; k < ils_pkg::CAPACITY; k++) begin
                if (ils_pkg::IDX_W'(k) == i_cmd.idx) begin
                    n_cells[k] = i_cmd.value;
                end
            end
        end else if (i_cmd.act == ils_pkg::ACT_DELETE) begin
            for (int k = 0; k < ils_pkg::CAPACITY - 1; k++) begin
                if (ils_pkg::IDX_W'(k) >= i_cmd.idx) begin
                    n_cells[k] = r_cells[k+1];
                end
            end
        end
    end

    // First stage of the read select: one-hot gating, OR within each group.
    always_comb begin
        for (int g = 0; g < ils_pkg::NGRP; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < ils_pkg::GRP; j++) begin
                if ((g * ils_pkg::GRP + j) < ils_pkg::CAPACITY) begin
                    if (ils_pkg::IDX_W'(g * ils_pkg::GRP + j) == i_cmd.idx) begin
                        n_grp[g] = n_grp[g] | r_cells[g * ils_pkg::GRP + j];
                    end
                end
            end
        end
    end

    // Second stage: OR across the registered groups.
    always_comb begin
        sel_word = '0;
        for (int g = 0; g < ils_pkg::NGRP; g++) begin
            sel_word = sel_word | r_grp[g];
        end
    end

    always_comb begin
        logic out_free;

        out_free    = !r_out_valid || i_ready;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_ready;
        o_pop       = 1'b0;
        load_out    = 1'b0;
        load_read   = 1'b0;

        case (r_state)
            ils_pkg::BK_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_pop = 1'b1;
                    if (i_cmd.act == ils_pkg::ACT_READ) begin
                        n_state = ils_pkg::BK_READ;
                    end else begin
                        load_out    = 1'b1;
                        n_out_valid = 1'b1;
                    end
                end
            end
            ils_pkg::BK_READ: begin
                load_read   = 1'b1;
                n_out_valid = 1'b1;
                n_state     = ils_pkg::BK_IDLE;
            end
            default: begin
                n_state = ils_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ils_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd   <= i_cmd;
            r_cells <= n_cells;
            r_grp   <= n_grp;
        end
        if (load_out) begin
            r_rd_value <= (i_cmd.act == ils_pkg::ACT_INSERT) ? '0 : i_cmd.value;
            r_status   <= i_cmd.status;
            r_length   <= i_cmd.length;
        end else if (load_read) begin
            r_rd_value <= sel_word;
            r_status   <= r_cmd.status;
            r_length   <= r_cmd.length;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_read_value   = r_rd_value;
    assign o_status       = r_status;
    assign o_length       = r_length;
    assign o_stat.reading = (r_state == ils_pkg::BK_READ);
    assign o_stat.pop     = o_pop;

endmodule

`default_nettype wire

// File: rtl/indexed_list_store_top.sv
// Top level of the indexed list store: front end, command queue and back end.
// Depends on ils_pkg, ils_front, ils_queue and ils_back.
`timescale 1ns / 1ps
`default_nettype none

// The indexed list store keeps an ordered list of up to 64 signed 32-bit
// entries and answers one result beat for every request beat. A request
// reads the entry at an index, inserts at the head, at the tail or before
// an index (an index equal to the length appends), or deletes the entry at
// an index; later entries move up or down by one place. The front end
// tracks the list length, checks indexes and capacity, and settles status
// and length at once, so a refused request never touches the entries. It
// hands each beat to a two-deep command queue and takes a new beat in every
// cycle while the queue has room. The back end holds the entries in a row
// of cells that all shift in the same cycle, so an insert, a delete or a
// refused request goes into the result register as it leaves the queue.
// A good read first passes the registered group stage of the two-level
// select tree in the read state, then loads the picked cell into the
// result register, and no new command is popped meanwhile. Writes and
// errors go at one beat per cycle while the consumer keeps ready high; the
// result register is refilled in the same cycle in which the consumer takes
// the previous result, so such a consumer sees no bubble between them. While
// a result waits the back end holds; the queue absorbs up to two more beats.
// Entries above the current length hold no defined value after reset; no
// clearing pass is needed since they are never read.

module indexed_list_store_top (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire  [ils_pkg::OP_W-1:0]           i_op,
    input  wire  [ils_pkg::POS_W-1:0]          i_position,
    input  wire  signed [ils_pkg::DATA_W-1:0]  i_value,
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic signed [ils_pkg::DATA_W-1:0]  o_read_value,
    output logic [ils_pkg::STAT_W-1:0]         o_status,
    output logic [ils_pkg::LEN_W-1:0]          o_length
);

    ils_pkg::t_cmd       front_cmd;
    ils_pkg::t_cmd       q_cmd;
    ils_pkg::t_back_stat back_stat;
    logic                push;
    logic                q_full;
    logic                q_valid;
    logic                pop;

    // Classifies each request beat against the tracked length.
    ils_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_op       (i_op),
        .i_position (i_position),
        .i_value    (i_value),
        .o_push     (push),
        .o_cmd      (front_cmd),
        .i_full     (q_full)
    );

    // Decouples the front end from stalls in the back end.
    ils_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    // Applies commands to the entry cells and produces result beats.
    ils_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_cmd        (q_cmd),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_length     (o_length),
        .o_stat       (back_stat)
    );

`ifndef NO_ASSERTIONS
    // The back end only pops a command that the queue actually holds.
    a_pop_has_cmd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.pop |-> q_valid)
        else $error("back end popped an empty command queue");

    // While a read walks the select tree the result register is empty.
    a_read_out_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.reading |-> !o_valid)
        else $error("result register busy during a read");

    // A full refusal only happens when the list is at capacity.
    a_full_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ils_pkg::ST_FULL)
            |-> (o_length == ils_pkg::LEN_W'(ils_pkg::CAPACITY)))
        else $error("full status with a list below capacity");
`endif

endmodule

`default_nettype wire

// File: test/tb_indexed_list_store_top.sv
// Self-checking testbench for indexed_list_store_top: list read, insert and delete traffic
// with random bursts, receiver stalls and a long output hold-off.
// Depends on ils_pkg and the RTL of indexed_list_store_top.
`timescale 1ns / 1ps

module tb_indexed_list_store_top;

    // A healthy run never goes this long without a beat on either side; the
    // longest legal pause is the receiver hold-off below.
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 200;
    // Cycles to keep watching the output after the last expected beat.
    localparam int DRAIN_TAIL   = 8;
    localparam int RANDOM_ITEMS = 1500;

    typedef struct {
        logic signed [ils_pkg::DATA_W-1:0] rd;
        ils_pkg::t_status                  st;
        logic [ils_pkg::LEN_W-1:0]         len;
    } t_list_result;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_valid;
    logic                              o_ready;
    logic [ils_pkg::OP_W-1:0]          i_op;
    logic [ils_pkg::POS_W-1:0]         i_position;
    logic signed [ils_pkg::DATA_W-1:0] i_value;
    logic                              o_valid;
    logic                              i_ready;
    logic signed [ils_pkg::DATA_W-1:0] o_read_value;
    logic [ils_pkg::STAT_W-1:0]        o_status;
    logic [ils_pkg::LEN_W-1:0]         o_length;

    // Shadow copy of the list, advanced once for every accepted request beat.
    logic signed [ils_pkg::DATA_W-1:0] shadow_list [ils_pkg::CAPACITY];
    int                                shadow_len;
    t_list_result                      pending_results [$];

    int  mismatch_count;
    int  result_beats;
    int  burst_left;
    bit  gaps_enabled;
    bit  hold_req;
    int  stall_cycles;

    indexed_list_store_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_length     (o_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Applies one request to the shadow list and returns the result beat the
    // block must produce for it. Index checks come before the full check, so
    // an insert past the end of a full list reports a range error.
    function automatic t_list_result apply_list_op(
            input logic [ils_pkg::OP_W-1:0] op,
            input logic [ils_pkg::POS_W-1:0] pos,
            input logic signed [ils_pkg::DATA_W-1:0] val);
        t_list_result r;
        int           p;
        int           ins_at;
        r.rd   = '0;
        r.st   = ils_pkg::ST_DONE;
        p      = int'(pos);
        ins_at = -1;
        case (op)
            ils_pkg::OP_READ: begin
                if (p < shadow_len) begin
                    r.rd = shadow_list[p];
                end else begin
                    r.rd = -1;
                    r.st = ils_pkg::ST_RANGE;
                end
            end
            ils_pkg::OP_INS_HEAD: ins_at = 0;
            ils_pkg::OP_INS_TAIL: ins_at = shadow_len;
            ils_pkg::OP_INS_AT: begin
                if (p > shadow_len) r.st = ils_pkg::ST_RANGE;
                else ins_at = p;
            end
            ils_pkg::OP_DELETE: begin
                if (p >= shadow_len) begin
                    r.st = ils_pkg::ST_RANGE;
                end else begin
                    for (int i = p; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
                    shadow_len--;
                end
            end
            default: r.st = ils_pkg::ST_RANGE;
        endcase
        if (ins_at >= 0) begin
            if (shadow_len >= ils_pkg::CAPACITY) begin
                r.st = ils_pkg::ST_FULL;
            end else begin
                for (int i = shadow_len; i > ins_at; i--) shadow_list[i] = shadow_list[i - 1];
                shadow_list[ins_at] = val;
                shadow_len++;
            end
        end
        r.len = shadow_len[ils_pkg::LEN_W-1:0];
        return r;
    endfunction

    // Values lean toward the signed extremes so the sign bit and the all-ones
    // pattern show up often next to plain random words.
    function automatic logic signed [ils_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return -1;
            3: return 0;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at result beat %0d: %s", result_beats, msg);
        mismatch_count++;
    endtask

    // Offers one request beat and returns once it has been accepted. While
    // gaps are enabled the sender works in bursts of random length with idle
    // cycles in between; inside a burst valid stays high from beat to beat.
    task automatic send_request(input logic [ils_pkg::OP_W-1:0] op,
                                input logic [ils_pkg::POS_W-1:0] pos,
                                input logic signed [ils_pkg::DATA_W-1:0] val);
        int gap;
        if (gaps_enabled && burst_left <= 0) begin
            gap = $urandom_range(1, 5);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        @(negedge i_clk);
        i_valid    <= 1'b1;
        i_op       <= op;
        i_position <= pos;
        i_value    <= val;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(apply_list_op(op, pos, val));
        burst_left--;
    endtask

    // Lowers valid and waits until every expected result beat has come out,
    // then watches a few more cycles so that a stray extra beat is caught.
    task automatic wait_results_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    // Random request that usually respects the current length, so the list
    // really grows and shrinks; the rest is noise over every op and index.
    task automatic send_random_request(input bit grow);
        int                        r;
        logic [ils_pkg::OP_W-1:0]  op;
        logic [ils_pkg::POS_W-1:0] pos;
        r   = $urandom_range(0, 99);
        pos = ils_pkg::POS_W'($urandom_range(0, 127));
        if (r < 15) begin
            op = ils_pkg::OP_W'($urandom_range(0, 7));
        end else begin
            r = $urandom_range(0, 99);
            if (r < 20 || (r >= (grow ? 80 : 45) && shadow_len == 0)) begin
                op = ils_pkg::OP_READ;
                if (shadow_len > 0) pos = ils_pkg::POS_W'($urandom_range(0, shadow_len - 1));
            end else if (r < (grow ? 80 : 45)) begin
                op = ils_pkg::OP_W'($urandom_range(ils_pkg::OP_INS_HEAD, ils_pkg::OP_INS_AT));
                if (op == ils_pkg::OP_INS_AT) pos = ils_pkg::POS_W'($urandom_range(0, shadow_len));
            end else begin
                op  = ils_pkg::OP_DELETE;
                pos = ils_pkg::POS_W'($urandom_range(0, shadow_len - 1));
            end
        end
        send_request(op, pos, pick_value());
    endtask

    // Corner cases on an empty and a short list: bad reads, deletes and
    // inserts, appends through insert-at, signed extremes, the largest
    // position and the three unused op codes.
    task automatic test_directed_corners();
        gaps_enabled = 1'b0;
        send_request(ils_pkg::OP_READ,     7'd0,   32'sd5);
        send_request(ils_pkg::OP_DELETE,   7'd0,   32'sd0);
        send_request(ils_pkg::OP_INS_AT,   7'd1,   32'sd9);
        send_request(ils_pkg::OP_INS_AT,   7'd0,   32'sh8000_0000);
        send_request(ils_pkg::OP_INS_HEAD, 7'd127, 32'sh7FFF_FFFF);
        send_request(ils_pkg::OP_INS_TAIL, 7'd0,   -32'sd1);
        send_request(ils_pkg::OP_INS_AT,   7'd3,   32'sd0);
        send_request(ils_pkg::OP_INS_AT,   7'd2,   32'sh1234_5678);
        send_request(ils_pkg::OP_READ,     7'd0,   32'sd0);
        send_request(ils_pkg::OP_READ,     7'd1,   32'sd0);
        send_request(ils_pkg::OP_READ,     7'd4,   32'sd0);
        send_request(ils_pkg::OP_READ,     7'd5,   32'sd0);
        send_request(ils_pkg::OP_READ,     7'd64,  32'sd0);
        send_request(ils_pkg::OP_READ,     7'd127, 32'sd0);
        send_request(ils_pkg::OP_DELETE,   7'd0,   32'sd0);
        send_request(ils_pkg::OP_DELETE,   7'd3,   32'sd0);
        send_request(ils_pkg::OP_DELETE,   7'd3,   32'sd0);
        send_request(ils_pkg::OP_DELETE,   7'd127, -32'sd1);
        send_request(3'd5,                 7'd127, -32'sd1);
        send_request(3'd6,                 7'd0,   32'sd0);
        send_request(3'd7,                 7'd127, -32'sd1);
        send_request(ils_pkg::OP_READ,     7'd1,   32'sd0);
        send_request(ils_pkg::OP_DELETE,   7'd1,   32'sd0);
        send_request(ils_pkg::OP_READ,     7'd0,   32'sd0);
        wait_results_drained();
    endtask

    // Fills the list to capacity, tries every kind of insert on the full
    // list, reads both ends, then deletes at random until it is empty.
    task automatic test_fill_to_capacity();
        logic [ils_pkg::OP_W-1:0] op;
        gaps_enabled = 1'b1;
        while (shadow_len < ils_pkg::CAPACITY) begin
            op = ils_pkg::OP_W'($urandom_range(ils_pkg::OP_INS_HEAD, ils_pkg::OP_INS_AT));
            send_request(op, ils_pkg::POS_W'($urandom_range(0, shadow_len)), pick_value());
        end
        send_request(ils_pkg::OP_INS_HEAD, 7'd0,  32'sd1);
        send_request(ils_pkg::OP_INS_TAIL, 7'd0,  32'sd2);
        send_request(ils_pkg::OP_INS_AT,   7'd10, 32'sd3);
        send_request(ils_pkg::OP_INS_AT,   7'd64, 32'sd4);
        send_request(ils_pkg::OP_INS_AT,   7'd65, 32'sd5);
        send_request(ils_pkg::OP_READ,     7'd63, 32'sd0);
        send_request(ils_pkg::OP_READ,     7'd64, 32'sd0);
        send_request(ils_pkg::OP_READ,     7'd0,  32'sd0);
        while (shadow_len > 0) begin
            if ($urandom_range(0, 3) == 0)
                send_request(ils_pkg::OP_READ,
                             ils_pkg::POS_W'($urandom_range(0, shadow_len - 1)), 0);
            send_request(ils_pkg::OP_DELETE,
                         ils_pkg::POS_W'($urandom_range(0, shadow_len - 1)), pick_value());
        end
        wait_results_drained();
    endtask

    // Long random run. The mix drifts between growing and shrinking phases so
    // the length sweeps the whole range, full list included.
    task automatic test_random_traffic();
        bit grow;
        int phase_left;
        gaps_enabled = 1'b1;
        grow         = 1'b1;
        phase_left   = $urandom_range(60, 200);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                grow       = ~grow;
                phase_left = $urandom_range(60, 200);
            end
            phase_left--;
            send_random_request(grow);
        end
        wait_results_drained();
    endtask

    // The receiver stops taking results for a long stretch while the sender
    // keeps offering beats back to back, so the block fills up and has to
    // hold off its input.
    task automatic test_output_hold_off();
        gaps_enabled = 1'b0;
        hold_req     = 1'b1;
        for (int n = 0; n < 150; n++) send_random_request(n < 90);
        wait_results_drained();
    endtask

    // Receiver: switches between a handful of stall patterns at random, and
    // serves a hold-off request by keeping ready low until the hold-off is over.
    initial begin
        int rx_mode;
        int rx_left;
        int rx_phase;
        i_ready  = 1'b0;
        rx_mode  = 0;
        rx_left  = 0;
        rx_phase = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (rx_left == 0) begin
                    rx_mode = $urandom_range(0, 3);
                    rx_left = $urandom_range(5, 80);
                end
                rx_left--;
                rx_phase++;
                case (rx_mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= 1'($urandom_range(0, 1));
                    2: i_ready <= (rx_phase % 4 == 0);
                    default: i_ready <= ($urandom_range(0, 99) < 85);
                endcase
            end
        end
    end

    // Result checker: every accepted result beat is matched against the
    // oldest expectation, field by field.
    always @(posedge i_clk) begin
        t_list_result exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing expected (len %0d)",
                                          o_length));
            end else begin
                exp_res = pending_results.pop_front();
                if (o_read_value !== exp_res.rd)
                    report_mismatch($sformatf("read_value %0d, expected %0d",
                                              o_read_value, exp_res.rd));
                if (o_status !== exp_res.st)
                    report_mismatch($sformatf("status %0d, expected %0d", o_status, exp_res.st));
                if (o_length !== exp_res.len)
                    report_mismatch($sformatf("length %0d, expected %0d", o_length, exp_res.len));
            end
            result_beats++;
        end
    end

    // Watchdog: counts cycles with work outstanding but no beat on either
    // channel, and gives up when the count reaches STALL_LIMIT.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) ||
            (!i_valid && pending_results.size() == 0)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_op           = '0;
        i_position     = '0;
        i_value        = '0;
        shadow_len     = 0;
        mismatch_count = 0;
        result_beats   = 0;
        burst_left     = 0;
        gaps_enabled   = 1'b0;
        hold_req       = 1'b0;
        stall_cycles   = 0;
        for (int i = 0; i < ils_pkg::CAPACITY; i++) shadow_list[i] = '0;
        // Synchronous reset, applied at the start and never asserted again.
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_corners();
        test_fill_to_capacity();
        test_random_traffic();
        test_output_hold_off();

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
